>>> hdl/sirt_pkg.sv
// Shared constants, codes and types of the sorted rank table.
package sirt_pkg;

	localparam int DEPTH      = 1024;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int LEN_W      = IDX_W + 1;
	localparam int KIND_W     = 3;
	localparam int STAT_W     = 3;
	localparam int QDEPTH     = 2;

	typedef enum logic [KIND_W-1:0] {
		OP_LOAD   = 3'd0,
		OP_REWIND = 3'd1,
		OP_NEXT   = 3'd2,
		OP_PEEK   = 3'd3,
		OP_NTH    = 3'd4,
		OP_RANK   = 3'd5,
		OP_BAD    = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_END    = 3'd1,
		ST_EDOM   = 3'd2,
		ST_NOTSUP = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_SHRD,
		S_SHWR,
		S_INS,
		S_LRES,
		S_EMIT
	} state_t;

	typedef struct packed {
		op_t                    op;
		logic signed [VALUE_BITS-1:0] value;
		logic [IDX_W-1:0]       index;
		logic                   start_new;
	} cmd_t;

endpackage

>>> hdl/sorted_index_rank_table.sv
// Top level of the sorted rank table: item queue front end and execution back end.
//
// channel   direction  handshake           fields
// command   in         start / busy        kind, value, index, start_new
// result    out        done (one cycle)    status, result_value, rank, position, length,
//                                          distinct
//
// Rank and load each run a binary search, each step one registered read of the
// sorted store. Load then moves every sorted entry above the insertion point up by one.
// Reset empties the list and clears the distinct flag; the stores hold no reset value.
// A two-item queue hides back-end work; busy rises when it is full. Results cannot stall.
module sorted_index_rank_table (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [sirt_pkg::KIND_W-1:0]            kind,
	input  logic signed [sirt_pkg::VALUE_BITS-1:0] value,
	input  logic [sirt_pkg::IDX_W-1:0]             index,
	input  logic                                   start_new,
	output logic                                   done,
	output logic [sirt_pkg::STAT_W-1:0]            status,
	output logic signed [sirt_pkg::VALUE_BITS-1:0] result_value,
	output logic signed [sirt_pkg::LEN_W-1:0]      rank,
	output logic [sirt_pkg::LEN_W-1:0]             position,
	output logic [sirt_pkg::LEN_W-1:0]             length,
	output logic                                   distinct
);
	import sirt_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	sirt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.value     (value),
		.index     (index),
		.start_new (start_new),
		.busy      (busy),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	sirt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.done         (done),
		.status       (status),
		.result_value (result_value),
		.rank         (rank),
		.position     (position),
		.length       (length),
		.distinct     (distinct)
	);

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length <= LEN_W'(DEPTH))
		else $error("length beyond depth");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> length == LEN_W'(DEPTH))
		else $error("full reported below depth");
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_OK |-> position <= length)
		else $error("cursor past list end");
`endif

endmodule

>>> hdl/sirt_front.sv
// Front end: accepts items, classifies the operation and queues them.
module sirt_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [sirt_pkg::KIND_W-1:0]            kind,
	input  logic signed [sirt_pkg::VALUE_BITS-1:0] value,
	input  logic [sirt_pkg::IDX_W-1:0]             index,
	input  logic                                   start_new,
	output logic                                   busy,
	output sirt_pkg::cmd_t                         cmd,
	output logic                                   cmd_valid,
	input  logic                                   cmd_pop
);
	import sirt_pkg::*;

	cmd_t             entry_q [QDEPTH];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push, pop;
	cmd_t             incoming;

	always_comb begin
		incoming.value     = value;
		incoming.index     = index;
		incoming.start_new = start_new;
		unique case (kind)
			OP_LOAD: incoming.op = OP_LOAD;
			OP_REWIND: incoming.op = OP_REWIND;
			OP_NEXT: incoming.op = OP_NEXT;
			OP_PEEK: incoming.op = OP_PEEK;
			OP_NTH: incoming.op = OP_NTH;
			OP_RANK: incoming.op = OP_RANK;
			default: incoming.op = OP_BAD;
		endcase
	end

	assign busy      = (cnt_q == 2'(QDEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = entry_q[rd_q];
	assign push      = start && !busy;
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= incoming;
	end

endmodule

>>> hdl/sirt_back.sv
// Back end: stores, sorted insertion, binary search and result registers.
module sirt_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sirt_pkg::cmd_t                         cmd,
	input  logic                                   cmd_valid,
	output logic                                   cmd_pop,
	output logic                                   done,
	output logic [sirt_pkg::STAT_W-1:0]            status,
	output logic signed [sirt_pkg::VALUE_BITS-1:0] result_value,
	output logic signed [sirt_pkg::LEN_W-1:0]      rank,
	output logic [sirt_pkg::LEN_W-1:0]             position,
	output logic [sirt_pkg::LEN_W-1:0]             length,
	output logic                                   distinct
);
	import sirt_pkg::*;

	logic signed [VALUE_BITS-1:0] lmem [DEPTH];
	logic signed [VALUE_BITS-1:0] smem [DEPTH];
	logic [IDX_W-1:0]             omem [DEPTH];

	logic signed [VALUE_BITS-1:0] ldata_q, sdata_q;
	logic [IDX_W-1:0]             odata_q;

	logic [IDX_W-1:0]             l_raddr, s_raddr, s_waddr, l_waddr;
	logic                         s_we, l_we;
	logic signed [VALUE_BITS-1:0] s_wdata;
	logic [IDX_W-1:0]             o_wdata;

	state_t                   state_q, state_n;
	logic [LEN_W-1:0]         len_q, len_n, cur_q, cur_n;
	logic                     dist_q, dist_n;
	logic [LEN_W-1:0]         lo_q, lo_n, hi_q, hi_n, j_q, j_n;
	logic [LEN_W-1:0]         mid_q, mid_n;
	cmd_t                     cmd_q, cmd_n;
	logic                     found_q, found_n;
	logic [IDX_W-1:0]         orig_q, orig_n;
	status_t                  stat_q, stat_n;
	logic signed [VALUE_BITS-1:0] res_q, res_n;
	logic [LEN_W-1:0]         rank_q, rank_n;
	logic [LEN_W:0]           mid_sum;
	logic [LEN_W-1:0]         len_eff;

	always_ff @(posedge clk) begin
		if (l_we) lmem[l_waddr] <= s_wdata;
		if (s_we) begin
			smem[s_waddr] <= s_wdata;
			omem[s_waddr] <= o_wdata;
		end
		ldata_q <= lmem[l_raddr];
		sdata_q <= smem[s_raddr];
		odata_q <= omem[s_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			cur_q   <= '0;
			dist_q  <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_n;
			len_q   <= len_n;
			cur_q   <= cur_n;
			dist_q  <= dist_n;
			lo_q    <= lo_n;
			hi_q    <= hi_n;
			j_q     <= j_n;
		end
	end

	always_ff @(posedge clk) begin
		mid_q   <= mid_n;
		cmd_q   <= cmd_n;
		found_q <= found_n;
		orig_q  <= orig_n;
		stat_q  <= stat_n;
		res_q   <= res_n;
		rank_q  <= rank_n;
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign len_eff = cmd.start_new ? '0 : len_q;

	always_comb begin
		state_n = state_q;
		len_n   = len_q;
		cur_n   = cur_q;
		dist_n  = dist_q;
		lo_n    = lo_q;
		hi_n    = hi_q;
		j_n     = j_q;
		mid_n   = mid_q;
		cmd_n   = cmd_q;
		found_n = found_q;
		orig_n  = orig_q;
		stat_n  = stat_q;
		res_n   = res_q;
		rank_n  = rank_q;
		cmd_pop = 1'b0;
		l_raddr = '0;
		s_raddr = '0;
		s_waddr = '0;
		l_waddr = '0;
		s_we    = 1'b0;
		l_we    = 1'b0;
		s_wdata = cmd_q.value;
		o_wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_n   = cmd;
					stat_n  = ST_OK;
					res_n   = '0;
					rank_n  = '0;
					found_n = 1'b0;
					lo_n    = '0;
					state_n = S_EMIT;
					unique case (cmd.op)
						OP_LOAD: begin
							if (cmd.start_new) begin
								len_n  = '0;
								cur_n  = '0;
								dist_n = 1'b1;
							end
							if (len_eff >= LEN_W'(DEPTH)) begin
								stat_n = ST_FULL;
							end else begin
								hi_n    = len_eff;
								state_n = S_SRCH;
							end
						end
						OP_REWIND: cur_n = '0;
						OP_NEXT, OP_PEEK: begin
							l_raddr = cur_q[IDX_W-1:0];
							if (cur_q >= len_q) stat_n = ST_END;
							else state_n = S_LRES;
						end
						OP_NTH: begin
							l_raddr = cmd.index;
							if ({1'b0, cmd.index} >= len_q) stat_n = ST_EDOM;
							else state_n = S_LRES;
						end
						OP_RANK: begin
							if (!dist_q) begin
								stat_n = ST_NOTSUP;
							end else if (len_q == '0) begin
								stat_n = ST_EDOM;
							end else begin
								hi_n    = len_q;
								state_n = S_SRCH;
							end
						end
						default: stat_n = ST_NOTSUP;
					endcase
				end
			end
			S_LRES: begin
				res_n = ldata_q;
				if (cmd_q.op == OP_NEXT) cur_n = cur_q + 1'b1;
				state_n = S_EMIT;
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					mid_n   = mid_sum[LEN_W:1];
					s_raddr = mid_sum[IDX_W:1];
					state_n = S_CMP;
				end else if (cmd_q.op == OP_LOAD) begin
					j_n     = len_q;
					state_n = S_SHRD;
				end else begin
					state_n = S_EMIT;
					if (lo_q == len_q) stat_n = ST_EDOM;
					else if (found_q) rank_n = {1'b0, orig_q};
					else if (lo_q == '0) stat_n = ST_EDOM;
					else rank_n = '1;
				end
			end
			S_CMP: begin
				state_n = S_SRCH;
				if (sdata_q == cmd_q.value) begin
					found_n = 1'b1;
					orig_n  = odata_q;
				end
				if (cmd_q.op == OP_LOAD) begin
					if (sdata_q > cmd_q.value) hi_n = mid_q;
					else lo_n = mid_q + 1'b1;
				end else begin
					if (sdata_q < cmd_q.value) lo_n = mid_q + 1'b1;
					else hi_n = mid_q;
				end
			end
			S_SHRD: begin
				if (j_q > lo_q) begin
					s_raddr = IDX_W'(j_q - 1'b1);
					state_n = S_SHWR;
				end else begin
					state_n = S_INS;
				end
			end
			S_SHWR: begin
				s_we    = 1'b1;
				s_waddr = j_q[IDX_W-1:0];
				s_wdata = sdata_q;
				o_wdata = odata_q;
				j_n     = j_q - 1'b1;
				state_n = S_SHRD;
			end
			S_INS: begin
				s_we    = 1'b1;
				s_waddr = lo_q[IDX_W-1:0];
				o_wdata = len_q[IDX_W-1:0];
				l_we    = 1'b1;
				l_waddr = len_q[IDX_W-1:0];
				len_n   = len_q + 1'b1;
				if (found_q) dist_n = 1'b0;
				state_n = S_EMIT;
			end
			S_EMIT: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	assign done         = (state_q == S_EMIT);
	assign status       = stat_q;
	assign result_value = res_q;
	assign rank         = rank_q;
	assign position     = cur_q;
	assign length       = len_q;
	assign distinct     = dist_q;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the sorted rank table: queued command driver, result monitor.
module tb_top;
	import sirt_pkg::*;

	typedef struct {
		logic [KIND_W-1:0]           kind;
		logic signed [VALUE_BITS-1:0] value;
		logic [IDX_W-1:0]            index;
		logic                        start_new;
	} item_t;

	typedef struct {
		logic [STAT_W-1:0]            status;
		logic signed [VALUE_BITS-1:0] result_value;
		logic [LEN_W-1:0]             rank;
		logic [LEN_W-1:0]             position;
		logic [LEN_W-1:0]             length;
		logic                         distinct;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [KIND_W-1:0] kind = '0;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic [IDX_W-1:0] index = '0;
	logic start_new = 1'b0;
	logic busy, done, distinct;
	logic [STAT_W-1:0] status;
	logic signed [VALUE_BITS-1:0] result_value;
	logic signed [LEN_W-1:0] rank;
	logic [LEN_W-1:0] position, length;

	sorted_index_rank_table u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.value(value), .index(index), .start_new(start_new), .done(done),
		.status(status), .result_value(result_value), .rank(rank),
		.position(position), .length(length), .distinct(distinct)
	);

	item_t   pending_items[$];
	answer_t expected_answers[$];
	int      n_accepted = 0;
	int      n_total = 0;
	int      n_fail = 0;
	int      n_cycles = 0;

	// Shadow copy of the table
	logic signed [VALUE_BITS-1:0] load_vals[DEPTH];
	logic signed [VALUE_BITS-1:0] sorted_vals[DEPTH];
	logic [IDX_W-1:0]             origin_pos[DEPTH];
	int                           held = 0;
	int                           cur = 0;
	logic                         all_distinct = 1'b0;

	initial forever #5 clk = ~clk;

	task automatic predict_answer(input item_t it);
		answer_t a;
		int p;
		a = '{default: '0};
		a.status = ST_OK;
		case (it.kind)
			OP_LOAD: begin
				if (it.start_new) begin
					held = 0;
					cur = 0;
					all_distinct = 1'b1;
				end
				if (held >= DEPTH) begin
					a.status = ST_FULL;
				end else begin
					p = 0;
					while (p < held && sorted_vals[p] <= it.value) p++;
					if (p > 0 && sorted_vals[p-1] == it.value) all_distinct = 1'b0;
					for (int j = held; j > p; j--) begin
						sorted_vals[j] = sorted_vals[j-1];
						origin_pos[j] = origin_pos[j-1];
					end
					sorted_vals[p] = it.value;
					origin_pos[p] = held[IDX_W-1:0];
					load_vals[held] = it.value;
					held++;
				end
			end
			OP_REWIND: cur = 0;
			OP_NEXT, OP_PEEK: begin
				if (cur >= held) begin
					a.status = ST_END;
				end else begin
					a.result_value = load_vals[cur];
					if (it.kind == OP_NEXT) cur++;
				end
			end
			OP_NTH: begin
				if (it.index >= held) a.status = ST_EDOM;
				else a.result_value = load_vals[it.index];
			end
			OP_RANK: begin
				if (!all_distinct) begin
					a.status = ST_NOTSUP;
				end else if (held == 0) begin
					a.status = ST_EDOM;
				end else if (it.value < sorted_vals[0] || it.value > sorted_vals[held-1]) begin
					a.status = ST_EDOM;
				end else begin
					a.rank = '1;
					for (int j = 0; j < held; j++)
						if (sorted_vals[j] == it.value) a.rank = LEN_W'(origin_pos[j]);
				end
			end
			default: a.status = ST_NOTSUP;
		endcase
		a.position = cur[LEN_W-1:0];
		a.length = held[LEN_W-1:0];
		a.distinct = all_distinct;
		expected_answers.push_back(a);
	endtask

	task automatic add_item(input logic [KIND_W-1:0] k, input logic signed [VALUE_BITS-1:0] v,
			input logic [IDX_W-1:0] i, input logic sn);
		item_t it;
		it.kind = k;
		it.value = v;
		it.index = i;
		it.start_new = sn;
		pending_items.push_back(it);
	endtask

	function automatic int idle_pct();
		if (n_accepted < n_total / 3) return 17;
		if (n_accepted < 2 * n_total / 3) return 50;
		return 0;
	endfunction

	// Driver: present the next item, hold it until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_answer('{kind, value, index, start_new});
				n_accepted <= n_accepted + 1;
			end
			if (!start || !busy) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct()) begin
					item_t it;
					it = pending_items.pop_front();
					kind <= it.kind;
					value <= it.value;
					index <= it.index;
					start_new <= it.start_new;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result status=%0d", $time, status);
				n_fail++;
			end else begin
				answer_t e;
				e = expected_answers.pop_front();
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					n_fail++;
				end
				if (result_value !== e.result_value) begin
					$display("%0t: result_value exp %0d got %0d", $time,
						e.result_value, result_value);
					n_fail++;
				end
				if (rank !== e.rank) begin
					$display("%0t: rank exp %0d got %0d", $time, $signed(e.rank), rank);
					n_fail++;
				end
				if (position !== e.position) begin
					$display("%0t: position exp %0d got %0d", $time, e.position, position);
					n_fail++;
				end
				if (length !== e.length) begin
					$display("%0t: length exp %0d got %0d", $time, e.length, length);
					n_fail++;
				end
				if (distinct !== e.distinct) begin
					$display("%0t: distinct exp %0d got %0d", $time, e.distinct, distinct);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= 600000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic signed [VALUE_BITS-1:0] held_vals[$];
		logic signed [VALUE_BITS-1:0] v;
		int n, m, r;
		bit dup_mode;

		// Directed: empty table after reset, then a short list with extreme values
		add_item(OP_RANK, 0, 0, 0);
		add_item(OP_NEXT, 0, 0, 0);
		add_item(OP_PEEK, 0, 0, 0);
		add_item(OP_NTH, 0, 0, 0);
		add_item(OP_BAD, -1, '1, 1);
		add_item(3'd7, 0, 0, 0);
		add_item(OP_REWIND, 0, 0, 0);
		add_item(OP_LOAD, 7, 0, 0);
		add_item(OP_LOAD, 32'sh8000_0000, 0, 1);
		add_item(OP_LOAD, 32'sh7FFF_FFFF, 0, 0);
		add_item(OP_LOAD, 0, 0, 0);
		add_item(OP_RANK, 32'sh8000_0000, 0, 0);
		add_item(OP_RANK, 32'sh7FFF_FFFF, 0, 0);
		add_item(OP_RANK, 5, 0, 0);
		add_item(OP_NEXT, 0, 0, 0);
		add_item(OP_PEEK, 0, 0, 0);
		add_item(OP_NTH, 0, 2, 0);
		add_item(OP_NTH, 0, '1, 0);
		add_item(OP_NEXT, 0, 0, 0);
		add_item(OP_NEXT, 0, 0, 0);
		add_item(OP_NEXT, 0, 0, 0);
		add_item(OP_LOAD, 0, 0, 0);
		add_item(OP_RANK, 0, 0, 0);
		add_item(OP_REWIND, 0, 0, 0);

		// Fill to full with ascending values, then overflow
		for (int j = 0; j < DEPTH; j++) add_item(OP_LOAD, j * 1000 - 500000, 0, j == 0);
		add_item(OP_LOAD, 3, 0, 0);
		add_item(OP_LOAD, 32'sh7FFF_FFFF, 0, 0);
		add_item(OP_RANK, 32'sh7FFF_FFFF, 0, 0);
		add_item(OP_RANK, 32'sh8000_0000, 0, 0);
		add_item(OP_RANK, 523000 - 500000, 0, 0);
		add_item(OP_RANK, (DEPTH - 1) * 1000 - 500000, 0, 0);
		add_item(OP_NTH, 0, '1, 0);
		add_item(OP_PEEK, 0, 0, 0);

		// Random: fresh lists followed by operation mixes
		while (pending_items.size() < 1250) begin
			n = $urandom_range(1, 12);
			dup_mode = ($urandom_range(2) == 0);
			held_vals.delete();
			for (int j = 0; j < n; j++) begin
				v = dup_mode ? $signed($urandom_range(8)) - 4 : $signed($urandom);
				held_vals.push_back(v);
				add_item(OP_LOAD, v, IDX_W'($urandom), j == 0);
			end
			m = $urandom_range(4, 14);
			for (int j = 0; j < m; j++) begin
				r = $urandom_range(99);
				v = held_vals[$urandom_range(held_vals.size() - 1)];
				if (r < 30) add_item(OP_RANK, v, IDX_W'($urandom), 1'($urandom));
				else if (r < 38) add_item(OP_RANK, v + 1, IDX_W'($urandom), 1'($urandom));
				else if (r < 42) add_item(OP_RANK, $urandom, IDX_W'($urandom), 1'($urandom));
				else if (r < 55) add_item(OP_NEXT, $urandom, IDX_W'($urandom), 1'($urandom));
				else if (r < 62) add_item(OP_PEEK, $urandom, IDX_W'($urandom), 1'($urandom));
				else if (r < 67) add_item(OP_REWIND, $urandom, IDX_W'($urandom), 1'($urandom));
				else if (r < 77) add_item(OP_NTH, $urandom,
					IDX_W'($urandom_range(held_vals.size() - 1)), 1'($urandom));
				else if (r < 82) add_item(OP_NTH, $urandom, IDX_W'($urandom), 1'($urandom));
				else if (r < 92) begin
					v = dup_mode ? $signed($urandom_range(8)) - 4 : $signed($urandom);
					held_vals.push_back(v);
					add_item(OP_LOAD, v, IDX_W'($urandom), 1'b0);
				end else if (r < 95) add_item(KIND_W'($urandom_range(6, 7)), $urandom,
					IDX_W'($urandom), 1'($urandom));
				else add_item(KIND_W'($urandom_range(1, 7)), $urandom,
					IDX_W'($urandom), 1'($urandom));
			end
		end
		n_total = pending_items.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0 && !start && expected_answers.size() == 0);
		repeat (100) @(posedge clk);
		if (n_fail == 0 && expected_answers.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
